@@ sv/hsn_pkg.sv @@
// shared constants and types for the hashed noise word core
`default_nettype none
package hsn_pkg;

  localparam int ENTRY_W  = 14;
  localparam int BOUNCE_W = 2;
  localparam int LANES    = 4;
  localparam int DIM_W    = BOUNCE_W + $clog2(LANES);
  localparam int WORD_W   = 32;
  localparam int BYTE_W   = 8;

  localparam int TILE_GRID = 128;
  localparam logic [WORD_W-1:0] GRID_CELLS = WORD_W'(TILE_GRID * TILE_GRID);

  localparam logic [WORD_W-1:0] MIX_MUL1  = 32'h85EB_CA6B;
  localparam logic [WORD_W-1:0] MIX_MUL2  = 32'hC2B2_AE35;
  localparam logic [WORD_W-1:0] DIM_MUL   = 32'h045D_9F3B;
  localparam logic [WORD_W-1:0] SEED_XOR  = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] TILE_MUL_X = 32'd73;
  localparam logic [WORD_W-1:0] TILE_MUL_Y = 32'd157;

  typedef logic [LANES-1:0][WORD_W-1:0] lane_vec_t;

  typedef struct packed {
    logic valid;
    logic in_grid;
  } stage_ctrl_t;

endpackage
`default_nettype wire

@@ sv/hashed_sobol_noise_word_core.sv @@
// top level: noise word pipeline, four dimension lanes plus tile seed lane
// path: an accepted request passes the premix register, the two mix lane registers
//   and the output register, and its word is then shown with done high
// throughput: one request per cycle; busy is always low, stages never stall
// reset: rst clears the stage valid bits and done; requests in flight are dropped
`default_nettype none
module hashed_sobol_noise_word_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [hsn_pkg::ENTRY_W-1:0]    entry_num,
  input  wire logic [hsn_pkg::BOUNCE_W-1:0]   bounce,
  output logic                                done,
  output logic [hsn_pkg::WORD_W-1:0]          packed_word
);

  hsn_pkg::lane_vec_t             lane_pre;
  hsn_pkg::lane_vec_t             lane_mix;
  logic [hsn_pkg::WORD_W-1:0]     seed_pre;
  logic [hsn_pkg::WORD_W-1:0]     seed_mix;
  hsn_pkg::stage_ctrl_t           ctrl1;
  hsn_pkg::stage_ctrl_t           ctrl2;
  hsn_pkg::stage_ctrl_t           ctrl3;
  logic [hsn_pkg::WORD_W-1:0]     packed_word_next;

  assign busy = 1'b0;

  hsn_premix u_premix (
    .clk         (clk),
    .rst         (rst),
    .accept      (start && !busy),
    .entry_num   (entry_num),
    .bounce      (bounce),
    .lane_pre    (lane_pre),
    .seed_pre    (seed_pre),
    .ctrl        (ctrl1)
  );

  for (genvar k = 0; k < hsn_pkg::LANES; k++) begin : g_lane
    hsn_mix_lane u_lane (
      .clk  (clk),
      .din  (lane_pre[k]),
      .dout (lane_mix[k])
    );
  end

  hsn_mix_lane u_seed (
    .clk  (clk),
    .din  (seed_pre),
    .dout (seed_mix)
  );

  always_comb begin
    packed_word_next = '0;
    for (int k = 0; k < hsn_pkg::LANES; k++) begin
      packed_word_next[k*hsn_pkg::BYTE_W +: hsn_pkg::BYTE_W] =
        lane_mix[k][hsn_pkg::BYTE_W-1:0];
    end
    // tile scramble only inside the grid
    if (ctrl3.in_grid) begin
      packed_word_next = packed_word_next ^ seed_mix;
    end
  end

  always_ff @(posedge clk) begin
    packed_word <= packed_word_next;
    if (rst) begin
      ctrl2 <= '0;
      ctrl3 <= '0;
      done  <= 1'b0;
    end else begin
      ctrl2 <= ctrl1;
      ctrl3 <= ctrl2;
      done  <= ctrl3.valid;
    end
  end

  a_req_gives_word: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted request did not produce a word after 4 cycles");

  a_no_spurious_word: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##4 !done)
    else $error("word strobed without a matching request");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl3.valid |=> (done && !busy))
    else $error("last stage valid did not reach the output strobe");

endmodule
`default_nettype wire

@@ sv/hsn_premix.sv @@
// first stage: carry-less dimension products, dimension salt and tile seed input
`default_nettype none
module hsn_premix (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic [hsn_pkg::ENTRY_W-1:0]       entry_num,
  input  wire logic [hsn_pkg::BOUNCE_W-1:0]      bounce,
  output hsn_pkg::lane_vec_t                     lane_pre,
  output logic [hsn_pkg::WORD_W-1:0]             seed_pre,
  output hsn_pkg::stage_ctrl_t                   ctrl
);

  localparam int STEP_W = hsn_pkg::DIM_W + 1;
  localparam int ACC_W  = hsn_pkg::ENTRY_W + STEP_W;

  hsn_pkg::lane_vec_t                 lane_pre_next;
  logic [hsn_pkg::WORD_W-1:0]         seed_pre_next;
  logic [hsn_pkg::ENTRY_W-1:0]        tile_x;
  logic [hsn_pkg::ENTRY_W-1:0]        tile_y;

  always_comb begin
    logic [hsn_pkg::DIM_W-1:0] dim;
    logic [STEP_W-1:0]         step;
    logic [ACC_W-1:0]          acc;
    for (int k = 0; k < hsn_pkg::LANES; k++) begin
      dim  = {bounce, ($clog2(hsn_pkg::LANES))'(k)};
      step = STEP_W'(dim) + STEP_W'(1);
      acc  = '0;
      // carry-less product of entry and dimension+1
      for (int p = 0; p < hsn_pkg::ENTRY_W; p++) begin
        if (entry_num[p]) begin
          acc = acc ^ (ACC_W'(step) << p);
        end
      end
      lane_pre_next[k] = hsn_pkg::WORD_W'(acc) ^
                         hsn_pkg::WORD_W'(hsn_pkg::WORD_W'(dim) * hsn_pkg::DIM_MUL);
    end
  end

  assign tile_x = entry_num % hsn_pkg::ENTRY_W'(hsn_pkg::TILE_GRID);
  assign tile_y = entry_num / hsn_pkg::ENTRY_W'(hsn_pkg::TILE_GRID);

  assign seed_pre_next =
    hsn_pkg::WORD_W'(hsn_pkg::WORD_W'(tile_x) * hsn_pkg::TILE_MUL_X +
                     hsn_pkg::WORD_W'(tile_y) * hsn_pkg::TILE_MUL_Y) ^ hsn_pkg::SEED_XOR;

  always_ff @(posedge clk) begin
    lane_pre <= lane_pre_next;
    seed_pre <= seed_pre_next;
    ctrl.in_grid <= hsn_pkg::WORD_W'(entry_num) < hsn_pkg::GRID_CELLS;
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= accept;
    end
  end

endmodule
`default_nettype wire

@@ sv/hsn_mix_lane.sv @@
// two-stage 32-bit finalizer lane, one constant multiply per stage
`default_nettype none
module hsn_mix_lane (
  input  wire logic                          clk,
  input  wire logic [hsn_pkg::WORD_W-1:0]    din,
  output logic [hsn_pkg::WORD_W-1:0]         dout
);

  logic [hsn_pkg::WORD_W-1:0] m1;
  logic [hsn_pkg::WORD_W-1:0] m2;
  logic [hsn_pkg::WORD_W-1:0] m1_next;
  logic [hsn_pkg::WORD_W-1:0] m2_next;

  assign m1_next = hsn_pkg::WORD_W'((din ^ (din >> 16)) * hsn_pkg::MIX_MUL1);
  assign m2_next = hsn_pkg::WORD_W'((m1 ^ (m1 >> 13)) * hsn_pkg::MIX_MUL2);

  always_ff @(posedge clk) begin
    m1 <= m1_next;
    m2 <= m2_next;
  end

  assign dout = m2 ^ (m2 >> 16);

endmodule
`default_nettype wire

@@ tb/tb_hashed_sobol_noise_word_core.sv @@
`timescale 1ns / 100ps
// testbench for the hashed noise word core: corner and random requests with idle bursts, words checked in order
module tb_hashed_sobol_noise_word_core;

  localparam int ENTRY_W    = hsn_pkg::ENTRY_W;
  localparam int BOUNCE_W   = hsn_pkg::BOUNCE_W;
  localparam int WORD_W     = hsn_pkg::WORD_W;
  localparam int RANDOM_REQUESTS = 632;
  localparam int QUIET_TAIL = 100;
  localparam int DRAIN_CYCLES = 12;

  localparam logic [31:0] FMIX_MUL_A = 32'h85EB_CA6B;
  localparam logic [31:0] FMIX_MUL_B = 32'hC2B2_AE35;
  localparam logic [31:0] DIM_SCRAMBLE = 32'h045D_9F3B;
  localparam logic [31:0] GOLDEN_XOR = 32'h9E37_79B9;
  localparam int unsigned GRID_SIDE = 128;

  typedef struct packed {
    logic [ENTRY_W-1:0]  entry;
    logic [BOUNCE_W-1:0] bounce;
  } noise_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [ENTRY_W-1:0] entry_num = '0;
  logic [BOUNCE_W-1:0] bounce = '0;
  logic busy;
  logic done;
  logic [WORD_W-1:0] packed_word;

  noise_request_t pending_requests[$];
  logic [WORD_W-1:0] expected_words[$];
  int gap_left = 0;
  int error_count = 0;
  int words_outstanding = 0;
  logic stimulus_done = 1'b0;

  hashed_sobol_noise_word_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .entry_num   (entry_num),
    .bounce      (bounce),
    .done        (done),
    .packed_word (packed_word)
  );

  function automatic logic [31:0] murmur_fmix(input logic [31:0] seed);
    logic [31:0] v;
    v = seed;
    v = v ^ (v >> 16);
    v = v * FMIX_MUL_A;
    v = v ^ (v >> 13);
    v = v * FMIX_MUL_B;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic logic [7:0] dim_noise_byte(input logic [ENTRY_W-1:0] entry,
                                                input logic [31:0] dim);
    logic [31:0] acc;
    logic [31:0] stride;
    logic [31:0] hashed;
    acc = '0;
    stride = dim + 32'd1;
    // digital shift sum over set entry bits
    for (int p = 0; p < ENTRY_W; p++) begin
      if (entry[p]) acc = acc ^ (stride << p);
    end
    hashed = murmur_fmix(acc ^ (dim * DIM_SCRAMBLE));
    return hashed[7:0];
  endfunction

  function automatic logic [WORD_W-1:0] noise_word(input logic [ENTRY_W-1:0] entry,
                                                   input logic [BOUNCE_W-1:0] bnc);
    logic [31:0] word;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] base;
    word = '0;
    base = 32'(bnc) * 32'd4;
    for (int k = 0; k < 4; k++) begin
      word[8*k +: 8] = dim_noise_byte(entry, base + 32'(k));
    end
    if (32'(entry) < GRID_SIDE * GRID_SIDE) begin
      tx = 32'(entry) % GRID_SIDE;
      ty = 32'(entry) / GRID_SIDE;
      word = word ^ murmur_fmix((tx * 32'd73 + ty * 32'd157) ^ GOLDEN_XOR);
    end
    return word;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin : drive
      noise_request_t req;
      if (start && busy) begin
        // request not taken yet, hold it on the ports
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 9);
          start <= 1'b0;
        end else begin
          req = pending_requests.pop_front();
          start <= 1'b1;
          entry_num <= req.entry;
          bounce <= req.bounce;
        end
      end else begin
        start <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // result monitor, also records accepted requests
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst) begin
      if (done) begin
        if (expected_words.size() == 0) begin
          report_mismatch("packed_word with no request outstanding", packed_word, '0);
        end else begin
          want = expected_words.pop_front();
          if (packed_word !== want) report_mismatch("packed_word", packed_word, want);
        end
      end
      if (start && !busy) expected_words.push_back(noise_word(entry_num, bounce));
    end
    words_outstanding <= expected_words.size();
  end

  initial begin
    noise_request_t req;
    logic [ENTRY_W-1:0] corner_entries[18] = '{
      14'd0, 14'd0, 14'd16383, 14'd16383, 14'd1, 14'd2, 14'd127, 14'd128, 14'd129,
      14'd8192, 14'd16256, 14'd16255, 14'h1555, 14'h2AAA, 14'd4095, 14'd12288,
      14'd64, 14'd8191
    };
    for (int i = 0; i < 18; i++) begin
      req.entry = corner_entries[i];
      req.bounce = BOUNCE_W'(i == 1 || i == 3 ? 3 : i % 4);
      pending_requests.push_back(req);
    end
    repeat (RANDOM_REQUESTS) begin
      req.entry = ENTRY_W'($urandom_range(0, 16383));
      req.bounce = BOUNCE_W'($urandom_range(0, 3));
      pending_requests.push_back(req);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (!stimulus_done) @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_words.size() != 0)
      report_mismatch("words never delivered", 32'(expected_words.size()), '0);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
